@@ hdl/char_lcd_text_writer_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD text writer
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_TEXT_WRITER_TOP_ASSERT_SVH
`define CHAR_LCD_TEXT_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define CLW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define CLW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/clw_pkg.sv @@
// ---------------------------------------------------------------------------
// clw_pkg
// Shared types, codes and helper functions of the character LCD text writer.
// ---------------------------------------------------------------------------
package clw_pkg;

    // Operation codes
    localparam logic [2:0] OP_INIT = 3'd0;
    localparam logic [2:0] OP_PUT  = 3'd1;
    localparam logic [2:0] OP_SET  = 3'd2;
    localparam logic [2:0] OP_CMD  = 3'd3;
    localparam logic [2:0] OP_DATA = 3'd4;
    localparam logic [2:0] OP_CTRL = 3'd5;

    // Configuration register indexes
    localparam logic CFG_NUM_COLS = 1'b0;
    localparam logic CFG_NUM_ROWS = 1'b1;

    localparam logic [5:0] NUM_COLS_RST = 6'd20;
    localparam logic [2:0] NUM_ROWS_RST = 3'd4;

    // Special characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // LCD command bytes
    localparam logic [7:0] LCD_FSET_1L   = 8'h20;
    localparam logic [7:0] LCD_FSET_2L   = 8'h28;
    localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_DDRAM     = 8'h80;
    localparam logic [4:0] LCD_DISP_HEAD = 5'b00001;

    // Entry list per operation and byte queue geometry
    localparam int LIST_LEN   = 7;
    localparam int LIST_CNT_W = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // One byte transfer (or a lone nibble when single is set)
    typedef struct packed {
        logic       single;
        logic [7:0] byte_val;
        logic       rs;
        logic [3:0] wait_fin;
        logic       last;
    } clw_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } clw_fifo_stat_t;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic clw_entry_t byte_entry(input logic [7:0] b, input logic rs,
                                              input logic [3:0] w);
        clw_entry_t e;
        e.single   = 1'b0;
        e.byte_val = b;
        e.rs       = rs;
        e.wait_fin = w;
        e.last     = 1'b0;
        return e;
    endfunction

    function automatic clw_entry_t cmd_entry(input logic [7:0] b);
        return byte_entry(b, 1'b0, (b < 8'd4) ? 4'd3 : 4'd2);
    endfunction

    function automatic clw_entry_t nib_entry(input logic [3:0] n, input logic [3:0] w);
        clw_entry_t e;
        e.single   = 1'b1;
        e.byte_val = {4'd0, n};
        e.rs       = 1'b0;
        e.wait_fin = w;
        e.last     = 1'b0;
        return e;
    endfunction

endpackage

@@ hdl/clw_front.sv @@
// ---------------------------------------------------------------------------
// clw_front
// Accept operations, track cursor and display bits, expand each operation
// into a list of byte transfers and push them into the byte queue.
// ---------------------------------------------------------------------------
module clw_front #(
    parameter int MAX_COLS = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [5:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          op,
    input  logic [7:0]          value,
    input  logic [7:0]          row,
    input  logic [5:0]          col,
    input  logic [2:0]          ctrl_mask,
    input  logic                ctrl_set,
    input  logic                fifo_full,
    output logic                push,
    output clw_pkg::clw_entry_t push_entry
);
    import clw_pkg::*;

    localparam logic [5:0] MAX_COLS_V = 6'(MAX_COLS);

    logic [5:0]      num_cols_reg;
    logic [2:0]      num_rows_reg;
    logic [1:0]      cursor_row_reg, cursor_row_next;
    logic [5:0]      cursor_col_reg, cursor_col_next;
    logic [2:0]      disp_reg, disp_next;
    clw_entry_t      list_reg [LIST_LEN];
    clw_entry_t      list_next [LIST_LEN];
    logic [LIST_CNT_W-1:0] cnt_reg, cnt_next;

    logic [1:0] last_row;
    logic [5:0] eff_cols;
    logic       accept;
    logic       wrap;
    logic [1:0] r1, r2;
    logic [5:0] c1;
    clw_entry_t e_wrap, e_main;
    logic [2:0] disp_upd;

    function automatic logic [1:0] fix_row(input logic [7:0] r, input logic [1:0] lr);
        return (r > {6'd0, lr}) ? 2'd0 : r[1:0];
    endfunction

    function automatic logic [7:0] ddram_addr(input logic [1:0] r, input logic [5:0] c);
        return LCD_DDRAM | ({2'd0, c} + row_base(r));
    endfunction

    always_comb
    begin
        if (num_rows_reg == 3'd0)
            last_row = 2'd0;
        else if (num_rows_reg > 3'd4)
            last_row = 2'd3;
        else
            last_row = 2'(num_rows_reg - 3'd1);
    end

    assign eff_cols = (num_cols_reg > MAX_COLS_V) ? MAX_COLS_V : num_cols_reg;

    assign push       = (cnt_reg != '0) && !fifo_full;
    assign push_entry = list_reg[0];
    assign in_ready   = (cnt_reg == '0) || ((cnt_reg == LIST_CNT_W'(1)) && push);
    assign accept     = in_valid && in_ready;

    // Put-character pieces: optional wrap, then newline, return or data
    always_comb
    begin
        wrap   = cursor_col_reg >= eff_cols;
        r1     = wrap ? fix_row({6'd0, cursor_row_reg} + 8'd1, last_row) : cursor_row_reg;
        c1     = wrap ? 6'd0 : cursor_col_reg;
        e_wrap = cmd_entry(ddram_addr(r1, 6'd0));
        if (value == CHAR_LF)
        begin
            r2     = fix_row({6'd0, r1} + 8'd1, last_row);
            e_main = cmd_entry(ddram_addr(r2, c1));
        end
        else if (value == CHAR_CR)
        begin
            r2     = fix_row({6'd0, r1}, last_row);
            e_main = cmd_entry(ddram_addr(r2, 6'd0));
        end
        else
        begin
            r2     = r1;
            e_main = byte_entry(value, 1'b1, 4'd1);
        end
        disp_upd = ctrl_set ? (disp_reg | ctrl_mask) : (disp_reg & ~ctrl_mask);
    end

    // Build the transfer list of the offered operation
    always_comb
    begin
        clw_entry_t            lst [LIST_LEN];
        logic [LIST_CNT_W-1:0] n;
        for (int i = 0; i < LIST_LEN; i++)
            lst[i] = '0;
        n               = '0;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        disp_next       = disp_reg;
        case (op)
            OP_INIT:
            begin
                lst[0] = nib_entry(4'd3, 4'd5);
                lst[1] = nib_entry(4'd3, 4'd1);
                lst[2] = nib_entry(4'd3, 4'd1);
                lst[3] = nib_entry(4'd2, 4'd1);
                lst[4] = cmd_entry((num_rows_reg > 3'd1) ? LCD_FSET_2L : LCD_FSET_1L);
                lst[5] = byte_entry(LCD_CLR_DISP, 1'b0, 4'd11);
                lst[6] = cmd_entry(LCD_ENTRY);
                n      = LIST_CNT_W'(7);
                cursor_row_next = 2'd0;
                cursor_col_next = 6'd0;
                disp_next       = 3'd4;
            end
            OP_PUT:
            begin
                if (wrap)
                begin
                    lst[0] = e_wrap;
                    lst[1] = e_main;
                    n      = LIST_CNT_W'(2);
                end
                else
                begin
                    lst[0] = e_main;
                    n      = LIST_CNT_W'(1);
                end
                cursor_row_next = r2;
                if (value == CHAR_LF)
                    cursor_col_next = c1;
                else if (value == CHAR_CR)
                    cursor_col_next = 6'd0;
                else
                    cursor_col_next = c1 + 6'd1;
            end
            OP_SET:
            begin
                cursor_row_next = fix_row(row, last_row);
                cursor_col_next = col;
                lst[0] = cmd_entry(ddram_addr(fix_row(row, last_row), col));
                n      = LIST_CNT_W'(1);
            end
            OP_CMD:
            begin
                lst[0] = cmd_entry(value);
                n      = LIST_CNT_W'(1);
            end
            OP_DATA:
            begin
                lst[0] = byte_entry(value, 1'b1, 4'd1);
                n      = LIST_CNT_W'(1);
            end
            OP_CTRL:
            begin
                disp_next = disp_upd;
                lst[0]    = cmd_entry({LCD_DISP_HEAD, disp_upd});
                n         = LIST_CNT_W'(1);
            end
            default:
            begin
                n = '0;
            end
        endcase
        // Mark the final transfer of this operation
        for (int i = 0; i < LIST_LEN; i++)
            if ((n != '0) && (LIST_CNT_W'(i) == n - LIST_CNT_W'(1)))
                lst[i].last = 1'b1;

        // Load on accept, otherwise shift out on push
        cnt_next = cnt_reg;
        for (int i = 0; i < LIST_LEN; i++)
            list_next[i] = list_reg[i];
        if (accept)
        begin
            for (int i = 0; i < LIST_LEN; i++)
                list_next[i] = lst[i];
            cnt_next = n;
        end
        else if (push)
        begin
            for (int i = 0; i < LIST_LEN - 1; i++)
                list_next[i] = list_reg[i + 1];
            list_next[LIST_LEN - 1] = '0;
            cnt_next = cnt_reg - LIST_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg   <= NUM_COLS_RST;
            num_rows_reg   <= NUM_ROWS_RST;
            cursor_row_reg <= 2'd0;
            cursor_col_reg <= 6'd0;
            disp_reg       <= 3'd0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == CFG_NUM_COLS))
                num_cols_reg <= cfg_data;
            if (cfg_we && (cfg_addr == CFG_NUM_ROWS))
                num_rows_reg <= cfg_data[2:0];
            if (accept)
            begin
                cursor_row_reg <= cursor_row_next;
                cursor_col_reg <= cursor_col_next;
                disp_reg       <= disp_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_LEN; i++)
            list_reg[i] <= list_next[i];
    end

endmodule

@@ hdl/clw_fifo.sv @@
// ---------------------------------------------------------------------------
// clw_fifo
// Short queue of byte transfers between the front and the back end.
// ---------------------------------------------------------------------------
module clw_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  clw_pkg::clw_entry_t     push_entry,
    input  logic                    pop,
    output clw_pkg::clw_entry_t     head,
    output clw_pkg::clw_fifo_stat_t stat
);
    import clw_pkg::*;

    clw_entry_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push, do_pop;

    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (FIFO_AW+1)'(1);
        end
    end

endmodule

@@ hdl/clw_back.sv @@
// ---------------------------------------------------------------------------
// clw_back
// Split queued byte transfers into nibbles, high nibble first (a lone
// nibble passes as it is), into an output register.
// ---------------------------------------------------------------------------
module clw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  clw_pkg::clw_entry_t head,
    input  logic                empty,
    output logic                pop,
    output logic                phase,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          nibble,
    output logic                reg_select,
    output logic [3:0]          wait_ms,
    output logic                last
);
    import clw_pkg::*;

    logic       valid_reg;
    logic       phase_reg;
    logic [3:0] nibble_reg, nibble_next;
    logic       rs_reg;
    logic [3:0] wait_reg, wait_next;
    logic       last_reg, last_next;
    logic       free, take;

    assign free = !valid_reg || out_ready;
    assign take = free && !empty;

    always_comb
    begin
        if (head.single || phase_reg)
        begin
            nibble_next = head.byte_val[3:0];
            wait_next   = head.wait_fin;
            last_next   = head.last;
            pop         = take;
        end
        else
        begin
            nibble_next = head.byte_val[7:4];
            wait_next   = 4'd0;
            last_next   = 1'b0;
            pop         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (free)
                valid_reg <= take;
            if (take && !head.single)
                phase_reg <= !phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            nibble_reg <= nibble_next;
            rs_reg     <= head.rs;
            wait_reg   <= wait_next;
            last_reg   <= last_next;
        end
    end

    assign phase      = phase_reg;
    assign out_valid  = valid_reg;
    assign nibble     = nibble_reg;
    assign reg_select = rs_reg;
    assign wait_ms    = wait_reg;
    assign last       = last_reg;

endmodule

@@ hdl/char_lcd_text_writer_top.sv @@
// ---------------------------------------------------------------------------
// char_lcd_text_writer_top
// Host side of a 4-bit character LCD link: turns text and control
// operations into nibble transfers with register select, wait and last.
// ---------------------------------------------------------------------------
//
//  Channel   | Direction | Content
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one operation request (op, value, row, col, ...)
//  m_axis    | out       | one nibble transfer (nibble, wait, rs, last)
//  cfg       | in        | register write: num_cols (0), num_rows (1)
//
//  A request expands into 0 to 10 nibbles (init gives 10, put-char up to 4,
//  unused op codes none); the back end sends one nibble per cycle while
//  m_axis is ready and the queue is not empty.
//  The front takes the next request while the previous one's last entry is
//  pushed. Reset clears cursor, display bits, queue and output valid;
//  num_cols and num_rows return to 20 and 4. Either side may stall any time.
//
module char_lcd_text_writer_top #(
    parameter int MAX_COLS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [5:0]  cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op[2:0] value[10:3] row[18:11] col[24:19]
                                        // ctrl_mask[27:25] ctrl_set[28], zero pad
    // nibble stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // nibble[3:0] wait_ms[7:4]
    output logic [0:0]  m_axis_tuser,   // reg_select[0]
    output logic        m_axis_tlast
);
    import clw_pkg::*;

    clw_entry_t     push_entry;
    clw_entry_t     head;
    clw_fifo_stat_t fifo_stat;
    logic           push;
    logic           pop;
    logic           phase;
    logic [3:0]     nibble;
    logic [3:0]     wait_ms;

    // Front: accept, classify and expand requests, hold cursor state
    clw_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr[0]),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tdata[2:0]),
        .value      (s_axis_tdata[10:3]),
        .row        (s_axis_tdata[18:11]),
        .col        (s_axis_tdata[24:19]),
        .ctrl_mask  (s_axis_tdata[27:25]),
        .ctrl_set   (s_axis_tdata[28]),
        .fifo_full  (fifo_stat.full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: decouple request expansion from nibble output
    clw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (fifo_stat)
    );

    // Back: split bytes into nibbles and drive the output register
    clw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (fifo_stat.empty),
        .pop        (pop),
        .phase      (phase),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .nibble     (nibble),
        .reg_select (m_axis_tuser[0]),
        .wait_ms    (wait_ms),
        .last       (m_axis_tlast)
    );

    assign m_axis_tdata = {wait_ms, nibble};

`include "char_lcd_text_writer_top_assert.svh"

    // Never push into a full queue: the front must see backpressure
    `CLW_ASSERT_IMP(a_no_push_full, push, !fifo_stat.full, "push into full queue")
    // Never pop an empty queue
    `CLW_ASSERT_IMP(a_no_pop_empty, pop, !fifo_stat.empty, "pop from empty queue")
    // While the low nibble is pending its byte must still sit at the head
    `CLW_ASSERT_IMP(a_phase_holds_entry, phase, !fifo_stat.empty,
        "low nibble pending without queued byte")
    // A popped byte always leaves a nibble in the output register
    `CLW_ASSERT_NEXT(a_pop_gives_valid, pop, m_axis_tvalid, "pop without output nibble")

endmodule
